@@ rtl/irbt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irbt_pkg
// Shared types, widths and per-band constant tables for the infrared
// brightness temperature pipeline.
// ----------------------------------------------------------------------------
package irbt_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAND = 2'd1,
    ST_ZERO = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  // side data that travels with every request through the chain
  typedef struct packed {
    logic    dec;   // result already settled
    logic    hot;   // settled result is full scale
    status_t st;
    logic [4:0] idx;
  } side_t;

  localparam logic [5:0]  BAND_FIRST = 6'd20;
  localparam logic [5:0]  BAND_LAST  = 6'd36;
  localparam logic [5:0]  BAND_HOLE  = 6'd26;
  localparam int          NBAND      = 17;
  localparam int          K1_W       = 35;
  localparam int          K2_W       = 28;
  localparam int          XW         = 52;
  localparam int          LW         = 30;
  localparam int          MW         = 31;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [23:0] TEN_E7     = 24'd10000000;
  localparam logic [16:0] BT_MAX     = 17'd131071;

  typedef logic [NBAND-1:0][K1_W-1:0] k1_tab_t;
  typedef logic [NBAND-1:0][K2_W-1:0] k2_tab_t;

  // central wavenumber in units of 1e-3 per cm
  function automatic logic [63:0] cwn_of(input logic [4:0] i);
    logic [63:0] v;
    case (i)
      5'd0:    v = 64'd2641775;
      5'd1:    v = 64'd2505277;
      5'd2:    v = 64'd2518028;
      5'd3:    v = 64'd2465428;
      5'd4:    v = 64'd2235815;
      5'd5:    v = 64'd2200346;
      5'd7:    v = 64'd1477967;
      5'd8:    v = 64'd1362737;
      5'd9:    v = 64'd1173190;
      5'd10:   v = 64'd1027715;
      5'd11:   v = 64'd908088;
      5'd12:   v = 64'd831540;
      5'd13:   v = 64'd748339;
      5'd14:   v = 64'd730896;
      5'd15:   v = 64'd718868;
      5'd16:   v = 64'd704537;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  // correction slope in units of 1e-7
  function automatic logic [23:0] slope_of(input logic [4:0] i);
    logic [23:0] v;
    case (i)
      5'd0:    v = 24'd9993411;
      5'd1:    v = 24'd9998646;
      5'd2:    v = 24'd9998584;
      5'd3:    v = 24'd9998682;
      5'd4:    v = 24'd9998819;
      5'd5:    v = 24'd9998845;
      5'd7:    v = 24'd9994877;
      5'd8:    v = 24'd9994918;
      5'd9:    v = 24'd9995495;
      5'd10:   v = 24'd9997398;
      5'd11:   v = 24'd9995608;
      5'd12:   v = 24'd9997256;
      5'd13:   v = 24'd9999160;
      5'd14:   v = 24'd9999167;
      5'd15:   v = 24'd9999191;
      5'd16:   v = 24'd9999281;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

  // correction intercept in units of 1e-7
  function automatic logic [22:0] icpt_of(input logic [4:0] i);
    logic [22:0] v;
    case (i)
      5'd0:    v = 23'd4770532;
      5'd1:    v = 23'd926266;
      5'd2:    v = 23'd975800;
      5'd3:    v = 23'd892924;
      5'd4:    v = 23'd731090;
      5'd5:    v = 23'd706042;
      5'd7:    v = 23'd2204921;
      5'd8:    v = 23'd2046087;
      5'd9:    v = 23'd1599191;
      5'd10:   v = 23'd825340;
      5'd11:   v = 23'd1302699;
      5'd12:   v = 23'd718183;
      5'd13:   v = 23'd197261;
      5'd14:   v = 23'd191357;
      5'd15:   v = 23'd181782;
      5'd16:   v = 23'd158304;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

  // first radiation constant term per band, Q16, built at elaboration
  function automatic k1_tab_t mk_k1_tab();
    k1_tab_t     t;
    logic [63:0] c;
    logic [63:0] c2;
    logic [63:0] c4;
    logic [63:0] c5;
    logic [63:0] k;
    for (int i = 0; i < NBAND; i++) begin
      c    = (cwn_of(5'(i)) * 64'd268435456 + 64'd500000) / 64'd1000000;
      c2   = (c * c + 64'd134217728) >> 28;
      c4   = (c2 * c2 + 64'd134217728) >> 28;
      c5   = (c4 * c + 64'd134217728) >> 28;
      k    = (c5 * 64'd119104283 + 64'd204800000) / 64'd409600000;
      t[i] = k[K1_W-1:0];
    end
    return t;
  endfunction

  // second radiation constant term per band, Q16, built at elaboration
  function automatic k2_tab_t mk_k2_tab();
    k2_tab_t     t;
    logic [63:0] k;
    for (int i = 0; i < NBAND; i++) begin
      k    = (64'd143877705 * cwn_of(5'(i)) * 64'd32 + 64'd24414062) / 64'd48828125;
      t[i] = k[K2_W-1:0];
    end
    return t;
  endfunction

  localparam k1_tab_t K1_TAB = mk_k1_tab();
  localparam k2_tab_t K2_TAB = mk_k2_tab();

endpackage
`default_nettype wire

@@ rtl/irbt_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irbt_div_cell
// One restoring long-division step: shifts in one numerator bit, compares
// with the divisor and shifts out one quotient bit, then registers.
// ----------------------------------------------------------------------------
module irbt_div_cell #(
  parameter int NW = 8,
  parameter int DW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           vld_i,
  input  irbt_pkg::side_t     side_i,
  input  wire logic [DW-1:0]  rem_i,
  input  wire logic [DW-1:0]  d_i,
  input  wire logic [NW-1:0]  nq_i,
  output logic                vld_o,
  output irbt_pkg::side_t     side_o,
  output logic [DW-1:0]       rem_o,
  output logic [DW-1:0]       d_o,
  output logic [NW-1:0]       nq_o
);
  import irbt_pkg::*;

  logic [DW:0]   sh;
  logic          qb;
  logic [DW:0]   diff;
  logic [DW-1:0] rem_nxt;
  logic [NW-1:0] nq_nxt;
  logic          vld_r;
  side_t         side_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] d_r;
  logic [NW-1:0] nq_r;

  // trial subtract
  always_comb begin
    sh      = {rem_i, nq_i[NW-1]};
    diff    = sh - {1'b0, d_i};
    qb      = (sh >= {1'b0, d_i});
    rem_nxt = qb ? diff[DW-1:0] : sh[DW-1:0];
    nq_nxt  = {nq_i[NW-2:0], qb};
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      rem_r  <= rem_nxt;
      d_r    <= d_i;
      nq_r   <= nq_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign rem_o  = rem_r;
  assign d_o    = d_r;
  assign nq_o   = nq_r;

endmodule
`default_nettype wire

@@ rtl/irbt_norm_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irbt_norm_cell
// One step of the leading-zero normalizer: shifts left by SH when the top
// SH bits are clear and adds SH to the zero count.
// ----------------------------------------------------------------------------
module irbt_norm_cell #(
  parameter int SH = 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   vld_i,
  input  irbt_pkg::side_t             side_i,
  input  wire logic [irbt_pkg::XW-1:0] w_i,
  input  wire logic [5:0]             lz_i,
  output logic                        vld_o,
  output irbt_pkg::side_t             side_o,
  output logic [irbt_pkg::XW-1:0]     w_o,
  output logic [5:0]                  lz_o
);
  import irbt_pkg::*;

  logic          hit;
  logic [XW-1:0] w_nxt;
  logic [5:0]    lz_nxt;
  logic          vld_r;
  side_t         side_r;
  logic [XW-1:0] w_r;
  logic [5:0]    lz_r;

  // shift when the top field is empty
  always_comb begin
    hit    = (w_i[XW-1 -: SH] == '0);
    w_nxt  = hit ? (w_i << SH) : w_i;
    lz_nxt = hit ? (lz_i + 6'(SH)) : lz_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      w_r    <= w_nxt;
      lz_r   <= lz_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign w_o    = w_r;
  assign lz_o   = lz_r;

endmodule
`default_nettype wire

@@ rtl/irbt_sq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irbt_sq_cell
// One fraction bit of log2: squares the Q30 mantissa, and when it reaches
// two sets fraction bit BIT and halves the mantissa.
// ----------------------------------------------------------------------------
module irbt_sq_cell #(
  parameter int BIT = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   vld_i,
  input  irbt_pkg::side_t             side_i,
  input  wire logic [irbt_pkg::MW-1:0] m_i,
  input  wire logic [irbt_pkg::LW-1:0] l_i,
  output logic                        vld_o,
  output irbt_pkg::side_t             side_o,
  output logic [irbt_pkg::MW-1:0]     m_o,
  output logic [irbt_pkg::LW-1:0]     l_o
);
  import irbt_pkg::*;

  logic [2*MW-1:0] p;
  logic [MW-1:0]   m_nxt;
  logic [LW-1:0]   l_nxt;
  logic            vld_r;
  side_t           side_r;
  logic [MW-1:0]   m_r;
  logic [LW-1:0]   l_r;

  // square and renormalize
  always_comb begin
    p     = m_i * m_i;
    m_nxt = p[2*MW-1] ? p[2*MW-1 -: MW] : p[2*MW-2 -: MW];
    l_nxt = l_i;
    l_nxt[BIT] = p[2*MW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      m_r    <= m_nxt;
      l_r    <= l_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign m_o    = m_r;
  assign l_o    = l_r;

endmodule
`default_nettype wire

@@ rtl/ir_brightness_temperature_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ir_brightness_temperature_core
// Inverse Planck brightness temperature for infrared bands 20 to 36, except 26.
// ----------------------------------------------------------------------------
// Usage
//   in channel: band number and Q8.16 radiance, one request per cycle.
//   out channel: Q9.8 kelvin and a status code, one result per request,
//   in request order.
//   The chain holds 51 divider cells for the radiance ratio, 6
//   normalizer cells, 24 squaring cells for the log2 fraction, one ln
//   scale stage, 53 divider cells for the temperature, three correction
//   stages, 19 divider cells for the slope division and the output
//   register. Throughput is one request per cycle unless stalled.
//   The whole chain advances together; when the output register holds a
//   result and out_stall is high, the chain freezes and in_stall is
//   raised in the same cycle, so no request is lost.
//   Reset clears every valid bit; the block is ready right after reset.
//   Invalid bands, zero radiance and out-of-range temperatures ride the
//   chain with a settled result so ordering is kept.
// ----------------------------------------------------------------------------
module ir_brightness_temperature_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [5:0]  in_band,
  input  wire logic [23:0] in_radiance,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [16:0]      out_brightness_temp,
  output logic [1:0]       out_status
);
  import irbt_pkg::*;

  localparam int D1N = 51;
  localparam int D2N = 53;
  localparam int D3N = 19;
  localparam int NRM = 6;
  localparam int SQN = 24;

  logic en;

  // chain advances unless a finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------- input decode ----------------
  logic       bad;
  logic [4:0] idx_c;
  side_t      side_c;

  always_comb begin
    bad   = (in_band < BAND_FIRST) || (in_band > BAND_LAST) || (in_band == BAND_HOLE);
    idx_c = bad ? 5'd0 : 5'(in_band - BAND_FIRST);
    side_c.idx = idx_c;
    side_c.hot = 1'b0;
    side_c.dec = bad || (in_radiance == '0);
    if (bad) begin
      side_c.st = ST_BAND;
    end else if (in_radiance == '0) begin
      side_c.st = ST_ZERO;
    end else begin
      side_c.st = ST_OK;
    end
  end

  // ---------------- ratio divider ----------------
  logic           d1_v    [D1N+1];
  side_t          d1_side [D1N+1];
  logic [23:0]    d1_rem  [D1N+1];
  logic [23:0]    d1_d    [D1N+1];
  logic [D1N-1:0] d1_nq   [D1N+1];

  assign d1_v[0]    = in_valid;
  assign d1_side[0] = side_c;
  assign d1_rem[0]  = '0;
  assign d1_d[0]    = in_radiance;
  assign d1_nq[0]   = {K1_TAB[idx_c], 16'd0};

  for (genvar g = 0; g < D1N; g++) begin : g_d1
    irbt_div_cell #(.NW(D1N), .DW(24)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(d1_v[g]), .side_i(d1_side[g]), .rem_i(d1_rem[g]),
      .d_i(d1_d[g]), .nq_i(d1_nq[g]),
      .vld_o(d1_v[g+1]), .side_o(d1_side[g+1]), .rem_o(d1_rem[g+1]),
      .d_o(d1_d[g+1]), .nq_o(d1_nq[g+1])
    );
  end

  // ---------------- normalizer ----------------
  logic          nm_v    [NRM+1];
  side_t         nm_side [NRM+1];
  logic [XW-1:0] nm_w    [NRM+1];
  logic [5:0]    nm_lz   [NRM+1];

  assign nm_v[0]    = d1_v[D1N];
  assign nm_side[0] = d1_side[D1N];
  assign nm_w[0]    = {1'b0, d1_nq[D1N]} + XW'(65536);
  assign nm_lz[0]   = '0;

  for (genvar g = 0; g < NRM; g++) begin : g_nm
    irbt_norm_cell #(.SH(32 >> g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(nm_v[g]), .side_i(nm_side[g]), .w_i(nm_w[g]), .lz_i(nm_lz[g]),
      .vld_o(nm_v[g+1]), .side_o(nm_side[g+1]), .w_o(nm_w[g+1]), .lz_o(nm_lz[g+1])
    );
  end

  // ---------------- log2 fraction ----------------
  logic          sq_v    [SQN+1];
  side_t         sq_side [SQN+1];
  logic [MW-1:0] sq_m    [SQN+1];
  logic [LW-1:0] sq_l    [SQN+1];
  logic [5:0]    ipart;

  // integer part is top bit position minus 16
  assign ipart      = 6'd35 - nm_lz[NRM];
  assign sq_v[0]    = nm_v[NRM];
  assign sq_side[0] = nm_side[NRM];
  assign sq_m[0]    = nm_w[NRM][XW-1 -: MW];
  assign sq_l[0]    = {ipart, 24'd0};

  for (genvar g = 0; g < SQN; g++) begin : g_sq
    irbt_sq_cell #(.BIT(SQN - 1 - g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(sq_v[g]), .side_i(sq_side[g]), .m_i(sq_m[g]), .l_i(sq_l[g]),
      .vld_o(sq_v[g+1]), .side_o(sq_side[g+1]), .m_o(sq_m[g+1]), .l_o(sq_l[g+1])
    );
  end

  // ---------------- natural log scale ----------------
  logic [61:0]   ln_p;
  logic [LW-1:0] ln_nxt;
  logic          ln_v_r;
  side_t         ln_side_r;
  logic [LW-1:0] ln_val_r;

  assign ln_p   = sq_l[SQN] * LN2_Q32;
  assign ln_nxt = LW'((ln_p + 62'h8000_0000) >> 32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ln_v_r <= 1'b0;
    end else if (en) begin
      ln_v_r <= sq_v[SQN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln_side_r <= sq_side[SQN];
      ln_val_r  <= ln_nxt;
    end
  end

  // ---------------- temperature divider ----------------
  logic           d2_v    [D2N+1];
  side_t          d2_side [D2N+1];
  logic [LW-1:0]  d2_rem  [D2N+1];
  logic [LW-1:0]  d2_d    [D2N+1];
  logic [D2N-1:0] d2_nq   [D2N+1];
  side_t          ln_side_c;

  // guard a zero logarithm as too hot
  always_comb begin
    ln_side_c = ln_side_r;
    if (!ln_side_r.dec && (ln_val_r == '0)) begin
      ln_side_c.dec = 1'b1;
      ln_side_c.hot = 1'b1;
      ln_side_c.st  = ST_SAT;
    end
  end

  assign d2_v[0]    = ln_v_r;
  assign d2_side[0] = ln_side_c;
  assign d2_rem[0]  = '0;
  assign d2_d[0]    = ln_val_r;
  assign d2_nq[0]   = {1'b0, K2_TAB[ln_side_r.idx], 24'd0} + D2N'(ln_val_r >> 1);

  for (genvar g = 0; g < D2N; g++) begin : g_d2
    irbt_div_cell #(.NW(D2N), .DW(LW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(d2_v[g]), .side_i(d2_side[g]), .rem_i(d2_rem[g]),
      .d_i(d2_d[g]), .nq_i(d2_nq[g]),
      .vld_o(d2_v[g+1]), .side_o(d2_side[g+1]), .rem_o(d2_rem[g+1]),
      .d_o(d2_d[g+1]), .nq_o(d2_nq[g+1])
    );
  end

  // ---------------- scale by 1e7, check 1024 K ----------------
  logic [D2N-1:0] tq;
  side_t          mu_side_c;
  logic           mu_v_r;
  side_t          mu_side_r;
  logic [49:0]    mu_p_r;

  assign tq = d2_nq[D2N];

  always_comb begin
    mu_side_c = d2_side[D2N];
    if (!mu_side_c.dec && (tq[D2N-1:26] != '0)) begin
      mu_side_c.dec = 1'b1;
      mu_side_c.hot = 1'b1;
      mu_side_c.st  = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_v_r <= 1'b0;
    end else if (en) begin
      mu_v_r <= d2_v[D2N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu_side_r <= mu_side_c;
      mu_p_r    <= tq[25:0] * TEN_E7;
    end
  end

  // ---------------- intercept subtract ----------------
  logic [49:0] off_c;
  side_t       co_side_c;
  logic        co_v_r;
  side_t       co_side_r;
  logic [49:0] co_n_r;

  assign off_c = {11'd0, icpt_of(mu_side_r.idx), 16'd0};

  // below the intercept reads as too cold
  always_comb begin
    co_side_c = mu_side_r;
    if (!mu_side_r.dec && (mu_p_r < off_c)) begin
      co_side_c.dec = 1'b1;
      co_side_c.hot = 1'b0;
      co_side_c.st  = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      co_v_r <= 1'b0;
    end else if (en) begin
      co_v_r <= mu_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      co_side_r <= co_side_c;
      co_n_r    <= mu_p_r - off_c;
    end
  end

  // ---------------- rounding offset ----------------
  logic        ad_v_r;
  side_t       ad_side_r;
  logic [49:0] ad_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ad_v_r <= 1'b0;
    end else if (en) begin
      ad_v_r <= co_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ad_side_r <= co_side_r;
      ad_n_r    <= co_n_r + {19'd0, slope_of(co_side_r.idx), 7'd0};
    end
  end

  // ---------------- slope divider ----------------
  logic           d3_v    [D3N+1];
  side_t          d3_side [D3N+1];
  logic [31:0]    d3_rem  [D3N+1];
  logic [31:0]    d3_d    [D3N+1];
  logic [D3N-1:0] d3_nq   [D3N+1];

  // quotient fits 19 bits since the divisor exceeds 2^31
  assign d3_v[0]    = ad_v_r;
  assign d3_side[0] = ad_side_r;
  assign d3_rem[0]  = {1'b0, ad_n_r[49:D3N]};
  assign d3_d[0]    = {slope_of(ad_side_r.idx), 8'd0};
  assign d3_nq[0]   = ad_n_r[D3N-1:0];

  for (genvar g = 0; g < D3N; g++) begin : g_d3
    irbt_div_cell #(.NW(D3N), .DW(32)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(d3_v[g]), .side_i(d3_side[g]), .rem_i(d3_rem[g]),
      .d_i(d3_d[g]), .nq_i(d3_nq[g]),
      .vld_o(d3_v[g+1]), .side_o(d3_side[g+1]), .rem_o(d3_rem[g+1]),
      .d_o(d3_d[g+1]), .nq_o(d3_nq[g+1])
    );
  end

  // ---------------- output register ----------------
  side_t          fs;
  logic [D3N-1:0] fq;
  logic [16:0]    bt_nxt;
  status_t        st_nxt;
  logic           out_v_r;
  logic [16:0]    bt_r;
  status_t        st_r;

  assign fs = d3_side[D3N];
  assign fq = d3_nq[D3N];

  always_comb begin
    if (fs.dec) begin
      bt_nxt = fs.hot ? BT_MAX : '0;
      st_nxt = fs.st;
    end else if (fq[D3N-1:17] != '0) begin
      bt_nxt = BT_MAX;
      st_nxt = ST_SAT;
    end else begin
      bt_nxt = fq[16:0];
      st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= d3_v[D3N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bt_r <= bt_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_valid           = out_v_r;
  assign out_brightness_temp = bt_r;
  assign out_status          = st_r;

endmodule
`default_nettype wire

@@ rtl/irbt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irbt_checker
// Port-level checks for the brightness temperature core, bound to the top.
// ----------------------------------------------------------------------------
module irbt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [16:0] out_brightness_temp,
  input wire logic [1:0]  out_status
);
  import irbt_pkg::*;

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_brightness_temp)
      && $stable(out_status))
    else $error("result changed while stalled");

  // input back-pressure only from a held result
  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // error codes carry a zero temperature
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BAND || out_status == ST_ZERO)
      |-> out_brightness_temp == '0)
    else $error("error result with nonzero temperature");

  // saturation goes to a rail
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SAT
      |-> out_brightness_temp == '0 || out_brightness_temp == BT_MAX)
    else $error("saturated result off the rails");

endmodule

bind ir_brightness_temperature_core irbt_checker u_irbt_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_brightness_temp(out_brightness_temp),
  .out_status(out_status)
);
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the infrared brightness temperature core. A
// bit-exact fixed-point model predicts kelvin and status for every accepted
// request; results are checked in order under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import irbt_pkg::*;

  // expected result of one request
  typedef struct {
    logic [16:0] bt;
    status_t     st;
    logic [5:0]  band;
    logic [23:0] rad;
  } temp_exp_t;

  // in-order store of predicted temperatures
  class temp_board;
    temp_exp_t pending[$];

    // per-band tables: wavenumber 1e-3, slope and intercept 1e-7
    function automatic logic [63:0] wn(int i);
      logic [63:0] t[17] = '{2641775, 2505277, 2518028, 2465428, 2235815, 2200346, 0,
                             1477967, 1362737, 1173190, 1027715, 908088, 831540,
                             748339, 730896, 718868, 704537};
      return t[i];
    endfunction
    function automatic logic [63:0] slp(int i);
      logic [63:0] t[17] = '{9993411, 9998646, 9998584, 9998682, 9998819, 9998845, 0,
                             9994877, 9994918, 9995495, 9997398, 9995608, 9997256,
                             9999160, 9999167, 9999191, 9999281};
      return t[i];
    endfunction
    function automatic logic [63:0] icp(int i);
      logic [63:0] t[17] = '{4770532, 926266, 975800, 892924, 731090, 706042, 0,
                             2204921, 2046087, 1599191, 825340, 1302699, 718183,
                             197261, 191357, 181782, 158304};
      return t[i];
    endfunction

    // log2 in Q24 of a Q16 value by repeated squaring
    function automatic logic [63:0] log2_fix(logic [63:0] x);
      int top;
      logic [63:0] m, fr;
      top = 0;
      fr = 0;
      for (int i = 0; i < 64; i++) if (x[i]) top = i;
      m = (top >= 30) ? (x >> (top - 30)) : (x << (30 - top));
      for (int i = 0; i < 24; i++) begin
        m = (m * m) >> 30;
        fr = fr << 1;
        if (m >= (64'd1 << 31)) begin
          fr = fr | 1;
          m = m >> 1;
        end
      end
      return (64'(top - 16) << 24) | fr;
    endfunction

    function automatic void predict(logic [5:0] band, logic [23:0] rad,
                                    output logic [16:0] bt, output status_t st);
      int ix;
      logic [63:0] c, c2, c4, c5, k1, k2, x, lnv, t, num, off, den, q;
      bt = 0;
      st = ST_OK;
      if (band < 20 || band > 36 || band == 26) begin
        st = ST_BAND;
        return;
      end
      if (rad == 0) begin
        st = ST_ZERO;
        return;
      end
      ix = band - 20;
      c = (wn(ix) * (64'd1 << 28) + 500000) / 1000000;
      c2 = (c * c + (64'd1 << 27)) >> 28;
      c4 = (c2 * c2 + (64'd1 << 27)) >> 28;
      c5 = (c4 * c + (64'd1 << 27)) >> 28;
      k1 = (c5 * 64'd119104283 + 204800000) / 409600000;
      k2 = (64'd143877705 * wn(ix) * 32 + 24414062) / 48828125;
      x = ((k1 << 16) / rad) + 65536;
      lnv = (log2_fix(x) * 64'd2977044472 + (64'd1 << 31)) >> 32;
      if (lnv == 0) begin
        bt = 17'h1ffff;
        st = ST_SAT;
        return;
      end
      t = ((k2 << 24) + (lnv >> 1)) / lnv;
      if (t >= (64'd1 << 26)) begin
        bt = 17'h1ffff;
        st = ST_SAT;
        return;
      end
      num = t * 10000000;
      off = icp(ix) * 65536;
      if (num < off) begin
        st = ST_SAT;
        return;
      end
      den = slp(ix) * 256;
      q = (num - off + (den >> 1)) / den;
      if (q > 131071) begin
        bt = 17'h1ffff;
        st = ST_SAT;
        return;
      end
      bt = q[16:0];
    endfunction

    function void note_request(logic [5:0] band, logic [23:0] rad);
      temp_exp_t e;
      predict(band, rad, e.bt, e.st);
      e.band = band;
      e.rad = rad;
      pending.push_back(e);
    endfunction

    // returns an empty string on a match
    function string check_result(logic [16:0] bt, logic [1:0] st);
      temp_exp_t e;
      if (pending.size() == 0) return "result with no request outstanding";
      e = pending.pop_front();
      if (bt !== e.bt || st !== e.st)
        return $sformatf("band %0d rad %0d: got bt %0d st %0d, want bt %0d st %0d",
                         e.band, e.rad, bt, st, e.bt, e.st);
      return "";
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [5:0]  in_band;
  logic [23:0] in_radiance;
  logic        out_valid;
  logic        out_stall;
  logic [16:0] out_brightness_temp;
  logic [1:0]  out_status;

  temp_board   board;
  int          err_cnt;
  int          req_cnt;
  int          res_cnt;
  int          sat_cnt;
  int          cyc;
  int          send_idle;
  int          recv_idle;

  ir_brightness_temperature_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_band             (in_band),
    .in_radiance         (in_radiance),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_brightness_temp (out_brightness_temp),
    .out_status          (out_status)
  );

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task automatic report(string msg);
    $display("mismatch @%0d: %s", cyc, msg);
    err_cnt++;
  endtask

  // receiver stall
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // watch both channels
  always @(posedge clk) begin
    string s;
    if (rst_n && in_valid && !in_stall) begin
      board.note_request(in_band, in_radiance);
      req_cnt++;
    end
    if (rst_n && out_valid && !out_stall) begin
      res_cnt++;
      if (out_status == ST_SAT) sat_cnt++;
      s = board.check_result(out_brightness_temp, out_status);
      if (s != "") report(s);
    end
  end

  // timeout
  always @(posedge clk) begin
    cyc++;
    if (cyc > 3000000) begin
      $display("timeout with %0d results outstanding", board.pending.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one request, with random gaps ahead of it
  task automatic send(logic [5:0] b, logic [23:0] r);
    bit hit;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_band <= b;
    in_radiance <= r;
    forever begin
      @(negedge clk);
      hit = !in_stall;
      @(posedge clk);
      if (hit) break;
    end
  endtask

  // let the last accepted request reach the board, then wait for all results
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic send_random();
    logic [5:0]  b;
    logic [23:0] r;
    int k;
    if ($urandom_range(9) == 0) b = 6'($urandom_range(63));
    else b = 6'($urandom_range(36, 20));
    k = $urandom_range(24, 1);
    r = 24'($urandom & ((32'd1 << k) - 1));
    if ($urandom_range(29) == 0) r = 0;
    if ($urandom_range(29) == 0) r = 24'hffffff;
    send(b, r);
  endtask

  initial begin
    board = new();
    send_idle = 37;
    recv_idle = 86;
    rst_n = 0;
    in_valid = 0;
    in_band = 0;
    in_radiance = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: band edges, the hole, zero and extreme radiance
    send(6'd0, 24'h010000);
    send(6'd63, 24'hffffff);
    send(6'd19, 24'h010000);
    send(6'd37, 24'h010000);
    send(6'd26, 24'h010000);
    send(6'd26, 24'h000000);
    send(6'd20, 24'h000000);
    send(6'd20, 24'h000001);
    send(6'd20, 24'hffffff);
    send(6'd36, 24'h000001);
    send(6'd36, 24'hffffff);
    send(6'd31, 24'h0a0000);
    send(6'd31, 24'h000100);
    send(6'd25, 24'h000010);
    send(6'd22, 24'h800000);
    send(6'd33, 24'h555555);
    send(6'd27, 24'h2aaaaa);
    send(6'd21, 24'h000fff);
    drain();

    // random in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 37 : (ph == 1) ? 86 : 0;
      recv_idle = (ph == 0) ? 86 : (ph == 1) ? 37 : 0;
      for (int i = 0; i < 670; i++) begin
        send_random();
        if (i == 300) drain();
      end
      drain();
    end

    // let the pipeline settle for anything unexpected
    repeat (400) @(posedge clk);
    $display("%0d requests sent, %0d results checked, %0d saturated,", req_cnt, res_cnt,
             sat_cnt);
    $display("over valid, invalid and hole bands and radiance spanning all bit sizes");
    if (err_cnt == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/irbt_pkg.sv
rtl/irbt_div_cell.sv
rtl/irbt_norm_cell.sv
rtl/irbt_sq_cell.sv
rtl/ir_brightness_temperature_core.sv
rtl/irbt_checker.sv
verif/tb_top.sv
